@@ design/csfu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC special function unit package
// Beat types, operation codes, gain constants and per-step angle tables for
// the unified circular / hyperbolic CORDIC pipeline.
// ----------------------------------------------------------------------------
package csfu_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int CIRC_ITERS = 28;
    localparam int HYP_ITERS  = 30;
    localparam int MODE_W     = 3;
    localparam int ARG_W      = 32;
    localparam int SRC_W      = ARG_W + 2;
    localparam int GAIN_W     = 29;
    localparam int PROD_W     = SRC_W + GAIN_W + 1;
    localparam int DATA_W     = 40;
    localparam int ANG_W      = 28;
    localparam int SHIFT_W    = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_SINCOS   = 3'd0,
        MODE_EXP      = 3'd1,
        MODE_COSHSINH = 3'd2,
        MODE_ATAN2    = 3'd3,
        MODE_LN       = 3'd4,
        MODE_SQRT     = 3'd5
    } t_mode;

    localparam logic [GAIN_W-1:0] INV_KC = 29'd163008219;
    localparam logic [GAIN_W-1:0] INV_KH = 29'd324135026;

    localparam logic signed [SRC_W-1:0] Q_ONE     = SRC_W'(1) << FRAC_BITS;
    localparam logic signed [SRC_W-1:0] Q_QUARTER = SRC_W'(1) << (FRAC_BITS - 2);

    localparam logic [ANG_W-1:0] CIRC_ANG [CIRC_ITERS] = '{
        28'd210828714, 28'd124459457, 28'd65760959,  28'd33381290,
        28'd16755422,  28'd8385879,   28'd4193963,   28'd2097109,
        28'd1048571,   28'd524287,    28'd262144,    28'd131072,
        28'd65536,     28'd32768,     28'd16384,     28'd8192,
        28'd4096,      28'd2048,      28'd1024,      28'd512,
        28'd256,       28'd128,       28'd64,        28'd32,
        28'd16,        28'd8,         28'd4,         28'd2
    };

    localparam logic [ANG_W-1:0] HYP_ANG [HYP_ITERS] = '{
        28'd147453245, 28'd68561855,  28'd33730852,  28'd16799113,
        28'd16799113,  28'd8391340,   28'd4194645,   28'd2097195,
        28'd1048581,   28'd524289,    28'd262144,    28'd131072,
        28'd65536,     28'd32768,     28'd32768,     28'd16384,
        28'd8192,      28'd4096,      28'd2048,      28'd1024,
        28'd512,       28'd256,       28'd128,       28'd64,
        28'd32,        28'd16,        28'd8,         28'd4,
        28'd2,         28'd1
    };

    localparam logic [SHIFT_W-1:0] HYP_SHIFT [HYP_ITERS] = '{
        5'd1,  5'd2,  5'd3,  5'd4,  5'd4,  5'd5,  5'd6,  5'd7,
        5'd8,  5'd9,  5'd10, 5'd11, 5'd12, 5'd13, 5'd13, 5'd14,
        5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22,
        5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd28
    };

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic signed [ARG_W-1:0] arg_a;
        logic signed [ARG_W-1:0] arg_b;
    } t_in_beat;

    typedef struct packed {
        logic [MODE_W-1:0]       mode_echo;
        logic signed [ARG_W-1:0] result_first;
        logic signed [ARG_W-1:0] result_second;
    } t_out_beat;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic                     hyp;
        logic                     vec;
        logic signed [SRC_W-1:0]  vx;
        logic signed [SRC_W-1:0]  vy;
        logic signed [DATA_W-1:0] z;
    } t_prep;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic                     hyp;
        logic                     vec;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } t_iter;

    typedef struct packed {
        logic               circ_on;
        logic [SHIFT_W-1:0] circ_shift;
        logic [SHIFT_W-1:0] hyp_shift;
        logic [ANG_W-1:0]   circ_ang;
        logic [ANG_W-1:0]   hyp_ang;
    } t_step;

    function automatic t_step step_info(input int idx);
        t_step st;
        st           = '0;
        st.hyp_shift = HYP_SHIFT[idx];
        st.hyp_ang   = HYP_ANG[idx];
        if (idx < CIRC_ITERS) begin
            st.circ_on    = 1'b1;
            st.circ_shift = SHIFT_W'(idx);
            st.circ_ang   = CIRC_ANG[idx];
        end
        return st;
    endfunction

endpackage

@@ design/csfu_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC micro-rotation stage
// One registered CORDIC iteration, circular or hyperbolic, rotation or
// vectoring, with the valid bit traveling alongside the vector.
// ----------------------------------------------------------------------------
module csfu_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  csfu_pkg::t_iter  i_data,
    input  csfu_pkg::t_step  i_step,
    output logic             o_valid,
    output csfu_pkg::t_iter  o_data
);

    localparam int DW = csfu_pkg::DATA_W;

    logic                          r_valid;
    csfu_pkg::t_iter               r_data;
    csfu_pkg::t_iter               n_data;
    logic [csfu_pkg::SHIFT_W-1:0]  sh;
    logic signed [DW-1:0]          ang;
    logic signed [DW-1:0]          xr;
    logic signed [DW-1:0]          yr;
    logic                          pos;
    logic                          step_on;

    always_comb begin
        sh      = i_data.hyp ? i_step.hyp_shift : i_step.circ_shift;
        ang     = i_data.hyp ? DW'(i_step.hyp_ang) : DW'(i_step.circ_ang);
        xr      = $signed(i_data.x) >>> sh;
        yr      = $signed(i_data.y) >>> sh;
        step_on = i_data.hyp || i_step.circ_on;
        pos     = i_data.vec ? i_data.y[DW-1] : !i_data.z[DW-1];
        n_data  = i_data;
        if (step_on) begin
            if (pos) begin
                n_data.x = i_data.hyp ? i_data.x + yr : i_data.x - yr;
                n_data.y = i_data.y + xr;
                n_data.z = i_data.z - ang;
            end else begin
                n_data.x = i_data.hyp ? i_data.x - yr : i_data.x + yr;
                n_data.y = i_data.y - xr;
                n_data.z = i_data.z + ang;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ design/cordic_special_function_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC special function unit
// Unified circular / hyperbolic CORDIC pipeline computing sin/cos, exp,
// cosh/sinh, atan2, ln and sqrt on Q4.28 arguments.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (i_valid / o_stall): operation selector and two Q4.28
//   arguments. A beat is taken at a rising edge with i_valid high and
//   o_stall low. Output beat (o_valid / i_stall): selector echo and two
//   Q4.28 results, taken at an edge with o_valid high and i_stall low.
//   Every input beat yields exactly one output beat, in order.
//   Pipeline: operand setup, gain multiply, 30 micro-rotation stages,
//   output register. Throughput: one beat per cycle while o_stall is
//   low; each stage holds one item and the pipeline advances in lockstep.
//   Selectors 6 and 7 give zero results with the selector echoed.
//   Reset (i_rst_n low, synchronous) drops every item in flight.
//   When the receiver stalls, the output register holds its beat and one
//   more finished beat parks in a skid register; once that is full the
//   pipeline freezes and o_stall rises until the receiver takes a beat.
// ----------------------------------------------------------------------------
module cordic_special_function_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  csfu_pkg::t_in_beat   i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output csfu_pkg::t_out_beat  o_data
);

    localparam int DW = csfu_pkg::DATA_W;
    localparam int SW = csfu_pkg::SRC_W;
    localparam int PW = csfu_pkg::PROD_W;
    localparam int RW = csfu_pkg::ARG_W;
    localparam int FB = csfu_pkg::FRAC_BITS;
    localparam int NS = csfu_pkg::HYP_ITERS;

    logic                           en;
    logic                           leave;

    logic                           r_pa_valid;
    csfu_pkg::t_prep                r_pa;
    csfu_pkg::t_prep                n_pa;
    logic signed [SW-1:0]           a_ext;

    logic                           r_pb_valid;
    csfu_pkg::t_iter                r_pb;
    csfu_pkg::t_iter                n_pb;
    logic [csfu_pkg::GAIN_W-1:0]    gain;
    logic signed [PW-1:0]           prod_x;
    logic signed [PW-1:0]           prod_y;

    logic [NS:0]                    s_valid;
    csfu_pkg::t_iter                s_data [NS+1];

    csfu_pkg::t_iter                last;
    logic signed [DW-1:0]           sum_xy;
    logic signed [DW-1:0]           z_dbl;
    csfu_pkg::t_out_beat            n_res;

    logic                           r_out_valid;
    csfu_pkg::t_out_beat            r_out;
    logic                           r_skid_valid;
    csfu_pkg::t_out_beat            r_skid;

    assign en      = !r_skid_valid;
    assign o_stall = r_skid_valid;

    // operand setup
    always_comb begin
        a_ext     = SW'($signed(i_data.arg_a));
        n_pa      = '0;
        n_pa.mode = i_data.mode;
        case (i_data.mode)
            csfu_pkg::MODE_SINCOS: begin
                n_pa.vx = csfu_pkg::Q_ONE;
                n_pa.z  = DW'($signed(i_data.arg_a));
            end
            csfu_pkg::MODE_EXP, csfu_pkg::MODE_COSHSINH: begin
                n_pa.hyp = 1'b1;
                n_pa.vx  = csfu_pkg::Q_ONE;
                n_pa.z   = DW'($signed(i_data.arg_a));
            end
            csfu_pkg::MODE_ATAN2: begin
                n_pa.vec = 1'b1;
                n_pa.vx  = SW'($signed(i_data.arg_b));
                n_pa.vy  = a_ext;
            end
            csfu_pkg::MODE_LN: begin
                n_pa.hyp = 1'b1;
                n_pa.vec = 1'b1;
                n_pa.vx  = a_ext + csfu_pkg::Q_ONE;
                n_pa.vy  = a_ext - csfu_pkg::Q_ONE;
            end
            csfu_pkg::MODE_SQRT: begin
                n_pa.hyp = 1'b1;
                n_pa.vec = 1'b1;
                n_pa.vx  = a_ext + csfu_pkg::Q_QUARTER;
                n_pa.vy  = a_ext - csfu_pkg::Q_QUARTER;
            end
            default: begin
                n_pa.vx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pa_valid <= 1'b0;
        end else if (en) begin
            r_pa_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pa <= n_pa;
        end
    end

    // gain compensation
    always_comb begin
        gain      = r_pa.hyp ? csfu_pkg::INV_KH : csfu_pkg::INV_KC;
        prod_x    = $signed({1'b0, gain}) * $signed(r_pa.vx);
        prod_y    = $signed({1'b0, gain}) * $signed(r_pa.vy);
        n_pb.mode = r_pa.mode;
        n_pb.hyp  = r_pa.hyp;
        n_pb.vec  = r_pa.vec;
        n_pb.x    = DW'(prod_x >>> FB);
        n_pb.y    = DW'(prod_y >>> FB);
        n_pb.z    = r_pa.z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pb_valid <= 1'b0;
        end else if (en) begin
            r_pb_valid <= r_pa_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pb <= n_pb;
        end
    end

    assign s_valid[0] = r_pb_valid;
    assign s_data[0]  = r_pb;

    for (genvar g = 0; g < NS; g++) begin : g_stage
        csfu_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (s_valid[g]),
            .i_data  (s_data[g]),
            .i_step  (csfu_pkg::step_info(g)),
            .o_valid (s_valid[g+1]),
            .o_data  (s_data[g+1])
        );
    end

    // result mapping
    always_comb begin
        last            = s_data[NS];
        sum_xy          = last.x + last.y;
        z_dbl           = last.z <<< 1;
        n_res.mode_echo = last.mode;
        case (last.mode)
            csfu_pkg::MODE_SINCOS: begin
                n_res.result_first  = last.y[RW-1:0];
                n_res.result_second = last.x[RW-1:0];
            end
            csfu_pkg::MODE_EXP: begin
                n_res.result_first  = sum_xy[RW-1:0];
                n_res.result_second = last.x[RW-1:0];
            end
            csfu_pkg::MODE_COSHSINH: begin
                n_res.result_first  = last.x[RW-1:0];
                n_res.result_second = last.y[RW-1:0];
            end
            csfu_pkg::MODE_ATAN2: begin
                n_res.result_first  = last.z[RW-1:0];
                n_res.result_second = last.x[RW-1:0];
            end
            csfu_pkg::MODE_LN: begin
                n_res.result_first  = z_dbl[RW-1:0];
                n_res.result_second = '0;
            end
            csfu_pkg::MODE_SQRT: begin
                n_res.result_first  = last.x[RW-1:0];
                n_res.result_second = '0;
            end
            default: begin
                n_res.result_first  = '0;
                n_res.result_second = '0;
            end
        endcase
    end

    assign leave = en && s_valid[NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= leave;
            end
        end else if (leave) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (leave) begin
            r_skid <= n_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a beat while output register is empty");

    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_stall && s_valid[NS]))
        else $error("skid register filled without a stalled output and a leaving item");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> (r_out_valid && !r_skid_valid))
        else $error("parked beat not moved to output register");
`endif

endmodule

@@ test/tb_cordic_special_function_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC special function unit testbench
// Streams directed and random operations through the unit with random idle
// gaps on both sides and one long output hold-off. Results are checked
// against a bit-true 64-bit CORDIC predictor built at start-up.
// ----------------------------------------------------------------------------
module tb_cordic_special_function_unit;

    localparam int  Q_FRAC      = csfu_pkg::FRAC_BITS;
    localparam int  N_CIRC      = csfu_pkg::CIRC_ITERS;
    localparam int  N_HYP       = csfu_pkg::HYP_ITERS;
    localparam int  MW          = csfu_pkg::MODE_W;
    localparam int  RANDOM_BEATS = 1300;
    localparam int  IDLE_LIMIT  = 1000;
    localparam int  DRAIN_CYCLES = 40;
    localparam int  HOLD_AT     = 300;
    localparam int  HOLD_CYCLES = 150;
    localparam logic [MW-1:0] MODE_RSVD6 = 3'd6;
    localparam logic [MW-1:0] MODE_RSVD7 = 3'd7;
    localparam logic signed [31:0] Q1_0  = 32'sd268435456;
    localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;

    class cordic_scoreboard;
        csfu_pkg::t_out_beat expected_q[$];
        int         mismatches;
        bit [63:0]  atan_tab[N_CIRC];
        bit [63:0]  atanh_tab[N_HYP];
        int         atanh_shift[N_HYP];
        bit [63:0]  inv_gain_circ;
        bit [63:0]  inv_gain_hyp;

        function new();
            bit [63:0] g;
            bit [63:0] h;
            bit [63:0] v;
            int        k;
            bit        held;
            mismatches = 0;
            g = 64'd1 << 62;
            h = 64'd1 << 62;
            for (int s = 0; s < N_CIRC; s++) begin
                v = (s == 0) ? 4 * atan_recip(5) - atan_recip(239) : series(s, 1'b1);
                atan_tab[s] = round_q(v);
                g += (2 * s < 64) ? (g >> (2 * s)) : 64'd0;
            end
            k = 1;
            held = 1'b0;
            for (int s = 0; s < N_HYP; s++) begin
                atanh_shift[s] = k;
                atanh_tab[s] = round_q(series(k, 1'b0));
                h -= (2 * k < 64) ? (h >> (2 * k)) : 64'd0;
                if ((k == 4 || k == 13) && !held) begin
                    held = 1'b1;
                end else begin
                    k++;
                    held = 1'b0;
                end
            end
            inv_gain_circ = round_q(inv_sqrt(g, (64'd3 << 62) / 5));
            inv_gain_hyp  = round_q(inv_sqrt(h, (64'd1 << 62) / 5 * 6));
        endfunction

        function bit [63:0] mul_q62(bit [63:0] a, bit [63:0] b);
            bit [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            return p[125:62];
        endfunction

        function bit [63:0] round_q(bit [63:0] v);
            return (v + (64'd1 << (61 - Q_FRAC))) >> (62 - Q_FRAC);
        endfunction

        function bit [63:0] series(int i, bit alt);
            bit [63:0] t;
            bit [63:0] sum;
            bit [63:0] term;
            int        k;
            t = 64'd1 << (62 - i);
            sum = 64'd0;
            k = 0;
            while (t != 0) begin
                term = t / (2 * k + 1);
                if (alt && k[0])
                    sum -= term;
                else
                    sum += term;
                t = (2 * i < 64) ? (t >> (2 * i)) : 64'd0;
                k++;
            end
            return sum;
        endfunction

        function bit [63:0] atan_recip(bit [63:0] n);
            bit [63:0] t;
            bit [63:0] sum;
            bit [63:0] term;
            int        k;
            t = (64'd1 << 62) / n;
            sum = 64'd0;
            k = 0;
            while (t != 0) begin
                term = t / (2 * k + 1);
                if (k[0])
                    sum -= term;
                else
                    sum += term;
                t = t / (n * n);
                k++;
            end
            return sum;
        endfunction

        function bit [63:0] inv_sqrt(bit [63:0] g, bit [63:0] y);
            bit [63:0] t;
            for (int k = 0; k < 16; k++) begin
                t = (64'd3 << 62) - mul_q62(g, mul_q62(y, y));
                y = mul_q62(y, t) >> 1;
            end
            return y;
        endfunction

        function bit [63:0] gain_mul(bit [63:0] k, bit [63:0] v);
            bit [63:0] p;
            p = k * v;
            return $signed(p) >>> Q_FRAC;
        endfunction

        function csfu_pkg::t_out_beat compute_result(csfu_pkg::t_in_beat beat);
            bit [63:0] a;
            bit [63:0] b;
            bit [63:0] x;
            bit [63:0] y;
            bit [63:0] z;
            bit [63:0] xr;
            bit [63:0] yr;
            bit [63:0] ang;
            bit [63:0] r0;
            bit [63:0] r1;
            bit        hyp;
            bit        vec;
            bit        pos;
            int        sh;
            int        n;
            csfu_pkg::t_out_beat res;
            a = {{32{beat.arg_a[31]}}, beat.arg_a};
            b = {{32{beat.arg_b[31]}}, beat.arg_b};
            x = 0;
            y = 0;
            z = 0;
            hyp = 1'b0;
            vec = 1'b0;
            res = '0;
            res.mode_echo = beat.mode;
            case (beat.mode)
                csfu_pkg::MODE_SINCOS: begin
                    x = inv_gain_circ;
                    z = a;
                end
                csfu_pkg::MODE_EXP, csfu_pkg::MODE_COSHSINH: begin
                    hyp = 1'b1;
                    x = inv_gain_hyp;
                    z = a;
                end
                csfu_pkg::MODE_ATAN2: begin
                    vec = 1'b1;
                    x = gain_mul(inv_gain_circ, b);
                    y = gain_mul(inv_gain_circ, a);
                end
                csfu_pkg::MODE_LN: begin
                    hyp = 1'b1;
                    vec = 1'b1;
                    x = gain_mul(inv_gain_hyp, a + (64'd1 << Q_FRAC));
                    y = gain_mul(inv_gain_hyp, a - (64'd1 << Q_FRAC));
                end
                csfu_pkg::MODE_SQRT: begin
                    hyp = 1'b1;
                    vec = 1'b1;
                    x = gain_mul(inv_gain_hyp, a + (64'd1 << (Q_FRAC - 2)));
                    y = gain_mul(inv_gain_hyp, a - (64'd1 << (Q_FRAC - 2)));
                end
                default: begin
                    return res;
                end
            endcase
            n = hyp ? N_HYP : N_CIRC;
            for (int s = 0; s < n; s++) begin
                sh  = hyp ? atanh_shift[s] : s;
                ang = hyp ? atanh_tab[s] : atan_tab[s];
                xr  = $signed(x) >>> sh;
                yr  = $signed(y) >>> sh;
                pos = vec ? y[63] : !z[63];
                if (pos) begin
                    x = hyp ? x + yr : x - yr;
                    y = y + xr;
                    z = z - ang;
                end else begin
                    x = hyp ? x - yr : x + yr;
                    y = y - xr;
                    z = z + ang;
                end
            end
            case (beat.mode)
                csfu_pkg::MODE_SINCOS:   begin r0 = y;      r1 = x; end
                csfu_pkg::MODE_EXP:      begin r0 = x + y;  r1 = x; end
                csfu_pkg::MODE_COSHSINH: begin r0 = x;      r1 = y; end
                csfu_pkg::MODE_ATAN2:    begin r0 = z;      r1 = x; end
                csfu_pkg::MODE_LN:       begin r0 = z << 1; r1 = 0; end
                default:                 begin r0 = x;      r1 = 0; end
            endcase
            res.result_first  = r0[31:0];
            res.result_second = r1[31:0];
            return res;
        endfunction

        function void note_input(csfu_pkg::t_in_beat beat);
            expected_q.push_back(compute_result(beat));
        endfunction

        function void check_result(csfu_pkg::t_out_beat got);
            csfu_pkg::t_out_beat exp_beat;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: mode %0d first %h second %h",
                             got.mode_echo, got.result_first, got.result_second);
                return;
            end
            exp_beat = expected_q.pop_front();
            if (got.mode_echo !== exp_beat.mode_echo ||
                got.result_first !== exp_beat.result_first ||
                got.result_second !== exp_beat.result_second) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %0d %h %h, got %0d %h %h",
                             exp_beat.mode_echo, exp_beat.result_first,
                             exp_beat.result_second, got.mode_echo,
                             got.result_first, got.result_second);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_stall = 1'b0;
    csfu_pkg::t_in_beat  i_data  = '0;
    logic      o_stall;
    logic      o_valid;
    csfu_pkg::t_out_beat o_data;

    cordic_scoreboard sb;
    int idle_cycles = 0;

    always #6 i_clk = ~i_clk;

    cordic_special_function_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    function automatic int draw_wait(int seq);
        if ((seq / 48) % 4 == 3)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    function automatic csfu_pkg::t_in_beat mk_beat(logic [MW-1:0] mode,
                                                   logic signed [31:0] a,
                                                   logic signed [31:0] b);
        csfu_pkg::t_in_beat beat;
        beat.mode  = mode;
        beat.arg_a = a;
        beat.arg_b = b;
        return beat;
    endfunction

    function automatic csfu_pkg::t_in_beat random_beat();
        csfu_pkg::t_in_beat beat;
        beat.arg_a = $urandom;
        beat.arg_b = $urandom;
        if ($urandom_range(0, 99) >= 60) begin
            beat.mode = MW'($urandom_range(0, 7));
            return beat;
        end
        beat.mode = csfu_pkg::t_mode'($urandom_range(0, 5));
        case (beat.mode)
            csfu_pkg::MODE_SINCOS:
                beat.arg_a = int'($urandom_range(0, 912680550)) - 456340275;
            csfu_pkg::MODE_EXP, csfu_pkg::MODE_COSHSINH:
                beat.arg_a = int'($urandom_range(0, 590558002)) - 295279001;
            csfu_pkg::MODE_ATAN2: begin
                beat.arg_a = int'($urandom_range(0, 1073741824)) - 536870912;
                beat.arg_b = int'($urandom_range(0, 1073741824)) - 536870912;
            end
            csfu_pkg::MODE_LN:
                beat.arg_a = $urandom_range(26843546, 2120640000);
            default:
                beat.arg_a = $urandom_range(8053064, 617401549);
        endcase
        return beat;
    endfunction

    task automatic drive_beat(input csfu_pkg::t_in_beat beat, input int seq);
        int gap;
        gap = draw_wait(seq);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= beat;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_input(i_data);
            if (o_valid && !i_stall)
                sb.check_result(o_data);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("cordic_special_function_unit test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : receiver
        int gap;
        int taken;
        bit held_off;
        taken = 0;
        held_off = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!held_off && taken == HOLD_AT) begin
                gap = HOLD_CYCLES;
                held_off = 1'b1;
            end else begin
                gap = draw_wait(taken);
            end
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            taken++;
        end
    end

    initial begin : stimulus
        csfu_pkg::t_in_beat directed_q[$];
        int       seq;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero arguments on every selector, then field extremes and nominal points
        for (int m = 0; m < 8; m++)
            directed_q.push_back(mk_beat(MW'(m), 32'sd0, 32'sd0));
        directed_q.push_back(mk_beat(csfu_pkg::MODE_SINCOS, Q1_0, 32'sd0));
        directed_q.push_back(mk_beat(csfu_pkg::MODE_SINCOS, -Q1_0, Q_MAX));
        directed_q.push_back(mk_beat(csfu_pkg::MODE_SINCOS, Q_MIN, Q_MAX));
        directed_q.push_back(mk_beat(csfu_pkg::MODE_EXP, Q1_0, 32'sd0));
        directed_q.push_back(mk_beat(csfu_pkg::MODE_EXP, Q_MAX, Q_MIN));
        directed_q.push_back(mk_beat(csfu_pkg::MODE_COSHSINH, -(Q1_0 / 2), 32'sd0));
        directed_q.push_back(mk_beat(csfu_pkg::MODE_COSHSINH, Q_MIN, 32'sd0));
        directed_q.push_back(mk_beat(csfu_pkg::MODE_ATAN2, Q1_0, Q1_0));
        directed_q.push_back(mk_beat(csfu_pkg::MODE_ATAN2, -Q1_0, -Q1_0));
        directed_q.push_back(mk_beat(csfu_pkg::MODE_ATAN2, Q_MAX, Q_MIN));
        directed_q.push_back(mk_beat(csfu_pkg::MODE_LN, Q1_0, 32'sd0));
        directed_q.push_back(mk_beat(csfu_pkg::MODE_LN, Q_MAX, 32'sd0));
        directed_q.push_back(mk_beat(csfu_pkg::MODE_SQRT, Q1_0, 32'sd0));
        directed_q.push_back(mk_beat(csfu_pkg::MODE_SQRT, Q_MIN, Q_MAX));
        directed_q.push_back(mk_beat(MODE_RSVD6, Q_MIN, Q_MAX));
        directed_q.push_back(mk_beat(MODE_RSVD7, Q_MAX, Q_MIN));

        seq = 0;
        foreach (directed_q[i]) begin
            drive_beat(directed_q[i], seq);
            seq++;
        end
        repeat (RANDOM_BEATS) begin
            drive_beat(random_beat(), seq);
            seq++;
        end
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("cordic_special_function_unit test passed");
        else
            $display("cordic_special_function_unit test failed");
        $finish;
    end

endmodule

@@ files.f @@
design/csfu_pkg.sv
design/csfu_stage.sv
design/cordic_special_function_unit.sv
test/tb_cordic_special_function_unit.sv
